@@ hw/rtl/mcuid_pkg.sv @@
// Shared types, operation codes and match patterns for the instruction decoder.
package mcuid_pkg;

    localparam int PC_BITS_DEF    = 16;
    localparam int JMP_ADDR_BITS  = 22;
    localparam int IN_TDATA_BITS  = 32;
    localparam int OUT_TDATA_BITS = 48;
    localparam int OUT_TUSER_BITS = 5;

    localparam logic [3:0] OPK_NOP  = 4'd0;
    localparam logic [3:0] OPK_ADD  = 4'd1;
    localparam logic [3:0] OPK_ADC  = 4'd2;
    localparam logic [3:0] OPK_INC  = 4'd3;
    localparam logic [3:0] OPK_ADIW = 4'd4;
    localparam logic [3:0] OPK_SBI  = 4'd5;
    localparam logic [3:0] OPK_CBI  = 4'd6;
    localparam logic [3:0] OPK_JMP  = 4'd7;
    localparam logic [3:0] OPK_RJMP = 4'd8;
    localparam logic [3:0] OPK_LDI  = 4'd9;

    // Major opcode groups, taken from instruction bits 15..10.
    localparam logic [5:0] TOP_NOP   = 6'h00;
    localparam logic [5:0] TOP_ADD   = 6'h03;
    localparam logic [5:0] TOP_ADC   = 6'h07;
    localparam logic [5:0] TOP_MISC  = 6'h25;
    localparam logic [5:0] TOP_IOBIT = 6'h26;
    localparam logic [5:0] TOP_RJMP0 = 6'h30;
    localparam logic [5:0] TOP_RJMP3 = 6'h33;
    localparam logic [5:0] TOP_LDI0  = 6'h38;
    localparam logic [5:0] TOP_LDI3  = 6'h3B;

    localparam logic [15:0] MASK_INC  = 16'hFE0F;
    localparam logic [15:0] PAT_INC   = 16'h9403;
    localparam logic [15:0] MASK_JMP  = 16'hFE0E;
    localparam logic [15:0] PAT_JMP   = 16'h940C;
    localparam logic [15:0] MASK_HIGH = 16'hFF00;
    localparam logic [15:0] PAT_ADIW  = 16'h9600;
    localparam logic [15:0] PAT_SBI   = 16'h9A00;
    localparam logic [15:0] PAT_CBI   = 16'h9800;

    typedef struct packed {
        logic [3:0] op_kind;
        logic [4:0] dest_reg;
        logic [4:0] src_reg;
        logic [7:0] immediate;
        logic [4:0] io_addr;
        logic [2:0] bit_index;
        logic [1:0] extra_cycles;
        logic       illegal;
    } t_dec_fields;

endpackage

@@ hw/rtl/mcuid_decode.sv @@
// Combinational decode of one instruction word and its next program counter.
module mcuid_decode #(
    parameter int PC_BITS = mcuid_pkg::PC_BITS_DEF
) (
    input  logic [15:0]            i_instr_word,
    input  logic [15:0]            i_second_word,
    input  logic [PC_BITS-1:0]     i_pc,
    output mcuid_pkg::t_dec_fields o_fields,
    output logic [PC_BITS-1:0]     o_next_pc
);
    import mcuid_pkg::*;

    logic [5:0]               top;
    logic [JMP_ADDR_BITS-1:0] jmp_target;
    logic [PC_BITS-1:0]       rjmp_offset;
    logic [PC_BITS-1:0]       pc_inc;
    t_dec_fields              f;
    logic [PC_BITS-1:0]       npc;

    assign top         = i_instr_word[15:10];
    assign jmp_target  = {i_instr_word[8:4], i_instr_word[0], i_second_word};
    assign rjmp_offset = PC_BITS'($signed(i_instr_word[11:0]));
    assign pc_inc      = i_pc + PC_BITS'(1);

    always_comb begin
        f     = '0;
        npc   = pc_inc;
        unique case (top) inside
            TOP_NOP: begin
                f.op_kind = OPK_NOP;
                f.illegal = (i_instr_word != 16'h0000);
            end
            TOP_ADD, TOP_ADC: begin
                f.op_kind  = (top == TOP_ADD) ? OPK_ADD : OPK_ADC;
                f.dest_reg = i_instr_word[8:4];
                f.src_reg  = {i_instr_word[9], i_instr_word[3:0]};
            end
            TOP_MISC: begin
                if ((i_instr_word & MASK_INC) == PAT_INC) begin
                    f.op_kind  = OPK_INC;
                    f.dest_reg = i_instr_word[8:4];
                end else if ((i_instr_word & MASK_JMP) == PAT_JMP) begin
                    f.op_kind      = OPK_JMP;
                    f.extra_cycles = 2'd2;
                    npc            = jmp_target[PC_BITS-1:0];
                end else if ((i_instr_word & MASK_HIGH) == PAT_ADIW) begin
                    // Register pairs 24, 26, 28 and 30 only.
                    f.op_kind      = OPK_ADIW;
                    f.dest_reg     = {2'b11, i_instr_word[5:4], 1'b0};
                    f.immediate    = {2'b00, i_instr_word[7:6], i_instr_word[3:0]};
                    f.extra_cycles = 2'd1;
                end else begin
                    f.illegal = 1'b1;
                end
            end
            TOP_IOBIT: begin
                if ((i_instr_word & MASK_HIGH) == PAT_SBI ||
                    (i_instr_word & MASK_HIGH) == PAT_CBI) begin
                    f.op_kind      = ((i_instr_word & MASK_HIGH) == PAT_SBI) ? OPK_SBI : OPK_CBI;
                    f.io_addr      = i_instr_word[7:3];
                    f.bit_index    = i_instr_word[2:0];
                    f.extra_cycles = 2'd1;
                end else begin
                    f.illegal = 1'b1;
                end
            end
            [TOP_RJMP0:TOP_RJMP3]: begin
                f.op_kind      = OPK_RJMP;
                f.extra_cycles = 2'd1;
                npc            = pc_inc + rjmp_offset;
            end
            [TOP_LDI0:TOP_LDI3]: begin
                f.op_kind   = OPK_LDI;
                f.dest_reg  = {1'b1, i_instr_word[7:4]};
                f.immediate = {i_instr_word[11:8], i_instr_word[3:0]};
            end
            default: begin
                f.illegal = 1'b1;
            end
        endcase

        // An unsupported word reports only the illegal flag and leaves the counter alone.
        if (f.illegal) begin
            f         = '0;
            f.illegal = 1'b1;
            npc       = i_pc;
        end
    end

    assign o_fields  = f;
    assign o_next_pc = npc;

endmodule

@@ hw/rtl/mcu_instruction_decoder_unit.sv @@
// Top level of the instruction decoder: input register, decode, result register and PC.
//
//  Channel  Dir  Fields (lowest bit first)
//  s_axis   in   tdata: instr_word[15:0], second_word[31:16]
//  m_axis   out  tdata: dest_reg, src_reg, immediate, io_addr, bit_index, next_pc,
//                       extra_cycles, zero pad; tuser: op_kind[3:0], illegal[4]
//
// Each item is decoded in the input register against the current program counter and
// then sits in the result register until taken. The block sustains one item per clock
// while the output is not stalled; the only loop is the PC register, which is updated
// in the same cycle that an item moves into the result register.
// Reset (synchronous, active low) clears both stage valid bits and sets the PC to zero.
// A stall on the output side holds the result and, one item later, the input register.
module mcu_instruction_decoder_unit #(
    parameter int PC_BITS = mcuid_pkg::PC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input item: instr_word[15:0], second_word[31:16].
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [mcuid_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
    // Result item: dest_reg[4:0], src_reg[9:5], immediate[17:10], io_addr[22:18],
    // bit_index[25:23], next_pc[41:26], extra_cycles[43:42], zeros[47:44].
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [mcuid_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
    // Result kind: op_kind[3:0], illegal[4].
    output logic [mcuid_pkg::OUT_TUSER_BITS-1:0]  m_axis_tuser
);
    import mcuid_pkg::*;

    localparam int ExtW = (PC_BITS > 16) ? PC_BITS : 16;

    // Input stage.
    logic               r_in_valid;
    logic [15:0]        r_in_instr;
    logic [15:0]        r_in_second;
    // Program counter of the item in the input stage.
    logic [PC_BITS-1:0] r_pc;
    // Result stage.
    logic               r_out_valid;
    t_dec_fields        r_out_fields;
    logic [15:0]        r_out_next_pc;

    t_dec_fields        dec_fields;
    logic [PC_BITS-1:0] dec_next_pc;
    logic [ExtW-1:0]    next_pc_ext;
    logic               out_free;
    logic               advance;
    logic               in_take;

    // The result register can load when it is empty or being drained this cycle.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    mcuid_decode #(
        .PC_BITS(PC_BITS)
    ) u_decode (
        .i_instr_word (r_in_instr),
        .i_second_word(r_in_second),
        .i_pc         (r_pc),
        .o_fields     (dec_fields),
        .o_next_pc    (dec_next_pc)
    );

    assign next_pc_ext = ExtW'(dec_next_pc);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_pc        <= dec_next_pc;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_instr  <= s_axis_tdata[15:0];
            r_in_second <= s_axis_tdata[31:16];
        end
        if (advance) begin
            r_out_fields  <= dec_fields;
            r_out_next_pc <= next_pc_ext[15:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000,
                            r_out_fields.extra_cycles,
                            r_out_next_pc,
                            r_out_fields.bit_index,
                            r_out_fields.io_addr,
                            r_out_fields.immediate,
                            r_out_fields.src_reg,
                            r_out_fields.dest_reg};
    assign m_axis_tuser  = {r_out_fields.illegal, r_out_fields.op_kind};

    // The PC moves only when an item passes from the input to the result register.
    a_pc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_pc))
        else $error("program counter changed without a decoded item");

    // An illegal word leaves the program counter where it was.
    a_illegal_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && dec_fields.illegal |=> r_pc == $past(r_pc))
        else $error("illegal word moved the program counter");

    // An illegal result carries no operation and no extra cycles.
    a_illegal_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_fields.illegal |->
            r_out_fields.op_kind == OPK_NOP && r_out_fields.extra_cycles == 2'd0)
        else $error("illegal result carries an operation");

    // Reset empties both stages.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_valid && !r_out_valid)
        else $error("stage valid after reset");

endmodule
